// ===== src/dedup_block_refcount_table_unit_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros used by the refcount table back end (drct_back)
// ---------------------------------------------------------------------------
`ifndef DEDUP_BLOCK_REFCOUNT_TABLE_UNIT_MACROS_SVH
`define DEDUP_BLOCK_REFCOUNT_TABLE_UNIT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define DRCT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while in reset.
`define DRCT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/drct_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// drct_pkg
// Shared constants, opcodes and types for the block refcount table.
// ---------------------------------------------------------------------------
package drct_pkg;

  localparam int BLOCKS     = 1024;
  localparam int COUNT_BITS = 16;
  localparam int TBL_AW     = $clog2(BLOCKS);
  localparam int TYPE_W     = 2;
  localparam int ID_W       = 10;
  localparam int VAL_W      = 16;
  localparam int TOT_W      = 32;
  localparam int Q_DEPTH    = 2;
  localparam int Q_AW       = $clog2(Q_DEPTH);

  typedef logic [COUNT_BITS-1:0] cnt_t;
  localparam cnt_t CNT_MAX = {COUNT_BITS{1'b1}};

  typedef enum logic [TYPE_W-1:0] {
    OP_LOAD    = 2'd0,
    OP_RELEASE = 2'd1,
    OP_ADD     = 2'd2,
    OP_QUERY   = 2'd3
  } op_t;

  // Classified request as it travels from front to back.
  typedef struct packed {
    op_t               op;
    logic              in_range;
    logic [TBL_AW-1:0] idx;
    logic [VAL_W-1:0]  load_value;
    logic [VAL_W-1:0]  file_refs;
  } drct_item_t;

  // Back-end status seen by the front end.
  typedef struct packed {
    logic pop;
    logic clearing;
  } back_stat_t;

  typedef enum logic [1:0] {
    B_CLEAR,
    B_IDLE,
    B_EXEC
  } b_state_t;

endpackage

// ===== src/dedup_block_refcount_table_unit.sv =====
`timescale 1ns / 1ps
// Flow: the front queues each accepted request; the back end reads its count
//   in B_IDLE, then writes back and registers the result in B_EXEC (held
//   while a stalled result fills the output register), one request at a time.
// Reset: synchronous, active low; afterwards a clearing pass zeroes all 1024
//   entries while in_stall stays high. Totals and handshake state clear at once.
// ---------------------------------------------------------------------------
// dedup_block_refcount_table_unit
// Reference-count table for deduplicated blocks: load, release, add, query.
// ---------------------------------------------------------------------------
// Structure:
//   drct_front - decodes each request transaction (opcode, in-range check)
//                and holds it in a two-entry queue.
//   drct_back  - pops the queue, reads the count, computes the update,
//                writes it back and registers the result transaction.
// The output register lets the front keep accepting while a result waits.
module dedup_block_refcount_table_unit import drct_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  // request channel
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [TYPE_W-1:0] in_req_type,
  input  logic [ID_W-1:0]   in_block_id,
  input  logic [VAL_W-1:0]  in_load_value,
  input  logic [VAL_W-1:0]  in_file_refs,
  // result channel
  output logic              out_valid,
  input  logic              out_stall,
  output logic [VAL_W-1:0]  out_ref_count,
  output logic              out_became_free,
  output logic              out_still_shared,
  output logic              out_present,
  output logic              out_reclaimable,
  output logic              out_range_error,
  output logic [TOT_W-1:0]  out_freed_total,
  output logic [TOT_W-1:0]  out_shared_total
);

  // queue between the two halves
  logic       q_valid;
  drct_item_t q_item;
  back_stat_t stat;

  // Front end: stalls when the queue is full or the table is being cleared.
  drct_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_req_type   (in_req_type),
    .in_block_id   (in_block_id),
    .in_load_value (in_load_value),
    .in_file_refs  (in_file_refs),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .stat          (stat)
  );

  // Back end: one request at a time, so a write-back always lands before
  // the next read and no forwarding is needed.
  drct_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_item           (q_item),
    .stat             (stat),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_ref_count    (out_ref_count),
    .out_became_free  (out_became_free),
    .out_still_shared (out_still_shared),
    .out_present      (out_present),
    .out_reclaimable  (out_reclaimable),
    .out_range_error  (out_range_error),
    .out_freed_total  (out_freed_total),
    .out_shared_total (out_shared_total)
  );

endmodule

// ===== src/drct_front.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// drct_front
// Accepts request transactions, decodes them and queues them for the back.
// ---------------------------------------------------------------------------
module drct_front import drct_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [TYPE_W-1:0] in_req_type,
  input  logic [ID_W-1:0]   in_block_id,
  input  logic [VAL_W-1:0]  in_load_value,
  input  logic [VAL_W-1:0]  in_file_refs,
  output logic              q_valid,
  output drct_item_t        q_item,
  input  back_stat_t        stat
);

  drct_item_t      q_mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_AW:0]   fill_r, fill_nxt;
  drct_item_t      item;
  logic            push;
  logic            pop;

  always_comb begin
    item.op         = op_t'(in_req_type);
    item.in_range   = 32'(in_block_id) < 32'(BLOCKS);
    item.idx        = TBL_AW'(in_block_id);
    item.load_value = in_load_value;
    item.file_refs  = in_file_refs;
  end

  assign in_stall = (fill_r == (Q_AW+1)'(Q_DEPTH)) || stat.clearing;
  assign push     = in_valid && !in_stall;
  assign pop      = stat.pop && q_valid;
  assign q_valid  = fill_r != '0;
  assign q_item   = q_mem_r[rd_ptr_r];

  always_comb begin
    fill_nxt = fill_r;
    if (push && !pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (pop && !push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      fill_r <= fill_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= item;
    end
  end

endmodule

// ===== src/drct_back.sv =====
`timescale 1ns / 1ps
`include "dedup_block_refcount_table_unit_macros.svh"
// ---------------------------------------------------------------------------
// drct_back
// Clears the table after reset, then does one read-modify-write per request.
// ---------------------------------------------------------------------------
module drct_back import drct_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  drct_item_t       q_item,
  output back_stat_t       stat,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [VAL_W-1:0] out_ref_count,
  output logic             out_became_free,
  output logic             out_still_shared,
  output logic             out_present,
  output logic             out_reclaimable,
  output logic             out_range_error,
  output logic [TOT_W-1:0] out_freed_total,
  output logic [TOT_W-1:0] out_shared_total
);

  cnt_t              tbl_mem [BLOCKS];
  cnt_t              rd_data_r;
  drct_item_t        cur_r;
  b_state_t          state_r, state_nxt;
  logic [TBL_AW-1:0] clr_addr_r;
  logic              clr_last;
  logic              out_free;
  logic              fire;
  logic              mem_we;
  logic [TBL_AW-1:0] mem_waddr;
  cnt_t              mem_wdata;

  cnt_t              cnt_old, cnt_upd;
  logic              freed_flag, shared_flag, recl_flag, err_flag;
  logic [TOT_W-1:0]  freed_r, freed_nxt, shared_r, shared_nxt;

  logic              out_valid_r;
  logic [VAL_W-1:0]  out_ref_count_r;
  logic              out_became_free_r, out_still_shared_r, out_present_r;
  logic              out_reclaimable_r, out_range_error_r;
  logic [TOT_W-1:0]  out_freed_total_r, out_shared_total_r;

  assign clr_last = clr_addr_r == TBL_AW'(BLOCKS - 1);
  assign out_free = !out_valid_r || !out_stall;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_CLEAR: if (clr_last) state_nxt = B_IDLE;
      B_IDLE:  if (q_valid)  state_nxt = B_EXEC;
      B_EXEC:  if (out_free) state_nxt = B_IDLE;
      default: state_nxt = B_CLEAR;
    endcase
  end

  // FSM outputs
  always_comb begin
    stat.clearing = 1'b0;
    stat.pop      = 1'b0;
    fire          = 1'b0;
    unique case (state_r)
      B_CLEAR: stat.clearing = 1'b1;
      B_IDLE:  stat.pop      = q_valid;
      B_EXEC:  fire          = out_free;
      default: stat.clearing = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= B_CLEAR;
      clr_addr_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (stat.clearing) begin
        clr_addr_r <= clr_addr_r + 1'b1;
      end
    end
  end

  // Request execution
  always_comb begin
    cnt_old     = cur_r.in_range ? rd_data_r : '0;
    cnt_upd     = cnt_old;
    freed_flag  = 1'b0;
    shared_flag = 1'b0;
    recl_flag   = 1'b0;
    err_flag    = 1'b0;
    unique case (cur_r.op)
      OP_LOAD: begin
        if (cur_r.in_range) cnt_upd = COUNT_BITS'(cur_r.load_value);
      end
      OP_RELEASE: begin
        if (cnt_old == '0) begin
          err_flag = 1'b1;
        end else begin
          cnt_upd     = cnt_old - cnt_t'(1);
          freed_flag  = cnt_upd == '0;
          shared_flag = cnt_upd != '0;
        end
      end
      OP_ADD: begin
        if (cur_r.in_range) begin
          if (cnt_old == CNT_MAX) begin
            err_flag = 1'b1;
          end else begin
            cnt_upd = cnt_old + cnt_t'(1);
          end
        end
      end
      OP_QUERY: recl_flag = 32'(cur_r.file_refs) == 32'(cnt_old);
      default:  recl_flag = 1'b0;
    endcase
  end

  assign freed_nxt  = freed_flag  ? freed_r + TOT_W'(1)  : freed_r;
  assign shared_nxt = shared_flag ? shared_r + TOT_W'(1) : shared_r;

  // Table port: clear sweep or write-back of the updated count
  assign mem_we    = stat.clearing || (fire && cur_r.in_range);
  assign mem_waddr = stat.clearing ? clr_addr_r : cur_r.idx;
  assign mem_wdata = stat.clearing ? '0 : cnt_upd;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      tbl_mem[mem_waddr] <= mem_wdata;
    end
    if (stat.pop) begin
      rd_data_r <= tbl_mem[q_item.idx];
    end
  end

  always_ff @(posedge clk) begin
    if (stat.pop) begin
      cur_r <= q_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      freed_r     <= '0;
      shared_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (fire) begin
        freed_r     <= freed_nxt;
        shared_r    <= shared_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_ref_count_r    <= VAL_W'(cnt_upd);
      out_became_free_r  <= freed_flag;
      out_still_shared_r <= shared_flag;
      out_present_r      <= cnt_upd != '0;
      out_reclaimable_r  <= recl_flag;
      out_range_error_r  <= err_flag;
      out_freed_total_r  <= freed_nxt;
      out_shared_total_r <= shared_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_ref_count    = out_ref_count_r;
  assign out_became_free  = out_became_free_r;
  assign out_still_shared = out_still_shared_r;
  assign out_present      = out_present_r;
  assign out_reclaimable  = out_reclaimable_r;
  assign out_range_error  = out_range_error_r;
  assign out_freed_total  = out_freed_total_r;
  assign out_shared_total = out_shared_total_r;

  `DRCT_ASSERT_IMP(a_no_pop_in_clear, clk, rst_n, state_r == B_CLEAR, !stat.pop, "pop during clear")
  `DRCT_ASSERT_NXT(a_fire_loads_out, clk, rst_n, fire, out_valid_r, "result not registered")
  `DRCT_ASSERT_NXT(a_freed_step, clk, rst_n, fire && freed_flag, freed_r == $past(freed_r) + TOT_W'(1), "freed total slip")
  `DRCT_ASSERT_IMP(a_err_excl, clk, rst_n, out_valid_r, !(out_range_error_r && (out_became_free_r || out_still_shared_r)), "error with release flag")

endmodule

// ===== dv/refcount_table_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// refcount_table_checker
// Watches both channels of the refcount table, keeps a shadow copy of the
// counts and totals, predicts each result and compares it field by field.
// ---------------------------------------------------------------------------
module refcount_table_checker import drct_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [TYPE_W-1:0] in_req_type,
  input  logic [ID_W-1:0]   in_block_id,
  input  logic [VAL_W-1:0]  in_load_value,
  input  logic [VAL_W-1:0]  in_file_refs,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [VAL_W-1:0]  out_ref_count,
  input  logic              out_became_free,
  input  logic              out_still_shared,
  input  logic              out_present,
  input  logic              out_reclaimable,
  input  logic              out_range_error,
  input  logic [TOT_W-1:0]  out_freed_total,
  input  logic [TOT_W-1:0]  out_shared_total,
  output int                fail_count,
  output int                pending,
  output int                results_seen,
  output int                freed_seen,
  output int                saturated_seen,
  output int                reclaim_seen
);

  localparam int MAX_REPORTS = 100;

  typedef struct packed {
    logic [VAL_W-1:0] ref_count;
    logic             became_free;
    logic             still_shared;
    logic             present;
    logic             reclaimable;
    logic             range_error;
    logic [TOT_W-1:0] freed_total;
    logic [TOT_W-1:0] shared_total;
  } refcount_result_t;

  cnt_t             shadow_counts [BLOCKS];
  logic [TOT_W-1:0] shadow_freed;
  logic [TOT_W-1:0] shadow_shared;
  refcount_result_t expected_results [$];
  int               mismatches = 0;
  int               checked = 0;
  int               freed_n = 0;
  int               saturated_n = 0;
  int               reclaim_n = 0;

  initial begin
    fail_count     = 0;
    pending        = 0;
    results_seen   = 0;
    freed_seen     = 0;
    saturated_seen = 0;
    reclaim_seen   = 0;
  end

  // Applies one request to the shadow table and returns its result.
  function automatic refcount_result_t predict_refcount(input op_t op,
                                                        input logic [ID_W-1:0] id,
                                                        input logic [VAL_W-1:0] load_v,
                                                        input logic [VAL_W-1:0] file_v);
    refcount_result_t r;
    cnt_t             cnt;
    logic             in_range;
    r        = '0;
    in_range = (int'(id) < BLOCKS);
    cnt      = in_range ? shadow_counts[id] : '0;
    case (op)
      OP_LOAD: begin
        if (in_range) cnt = cnt_t'(load_v);
      end
      OP_RELEASE: begin
        if (cnt == '0) begin
          r.range_error = 1'b1;
        end else begin
          cnt = cnt - 1'b1;
          if (cnt == '0) begin
            r.became_free = 1'b1;
            shadow_freed  = shadow_freed + 1'b1;
          end else begin
            r.still_shared = 1'b1;
            shadow_shared  = shadow_shared + 1'b1;
          end
        end
      end
      OP_ADD: begin
        if (in_range) begin
          if (cnt == CNT_MAX) r.range_error = 1'b1;
          else                cnt = cnt + 1'b1;
        end
      end
      default: begin
        r.reclaimable = (TOT_W'(file_v) == TOT_W'(cnt));
      end
    endcase
    if (in_range) shadow_counts[id] = cnt;
    r.ref_count    = VAL_W'(cnt);
    r.present      = (cnt != '0);
    r.freed_total  = shadow_freed;
    r.shared_total = shadow_shared;
    return r;
  endfunction

  task automatic check_field(input string field, input logic [TOT_W-1:0] want_v,
                             input logic [TOT_W-1:0] got_v);
    if (want_v !== got_v) begin
      mismatches++;
      // later mismatches are counted but not printed
      if (mismatches <= MAX_REPORTS)
        $display("%0t: %s mismatch on result %0d: expected %0h, actual %0h",
                 $time, field, checked, want_v, got_v);
    end
  endtask

  always @(posedge clk) begin : monitor
    refcount_result_t want;
    if (!rst_n) begin
      foreach (shadow_counts[i]) shadow_counts[i] = '0;
      shadow_freed  = '0;
      shadow_shared = '0;
      expected_results.delete();
    end else begin
      // retire first: a result never belongs to a request taken this cycle
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: unexpected result transaction: expected none, actual ref_count %0h",
                     $time, out_ref_count);
        end else begin
          want = expected_results.pop_front();
          check_field("ref_count", TOT_W'(want.ref_count), TOT_W'(out_ref_count));
          check_field("became_free", TOT_W'(want.became_free), TOT_W'(out_became_free));
          check_field("still_shared", TOT_W'(want.still_shared), TOT_W'(out_still_shared));
          check_field("present", TOT_W'(want.present), TOT_W'(out_present));
          check_field("reclaimable", TOT_W'(want.reclaimable), TOT_W'(out_reclaimable));
          check_field("range_error", TOT_W'(want.range_error), TOT_W'(out_range_error));
          check_field("freed_total", want.freed_total, out_freed_total);
          check_field("shared_total", want.shared_total, out_shared_total);
          checked++;
        end
      end
      if (in_valid && !in_stall) begin
        want = predict_refcount(op_t'(in_req_type), in_block_id, in_load_value, in_file_refs);
        expected_results.push_back(want);
        if (want.became_free) freed_n++;
        if (want.range_error) saturated_n++;
        if (want.reclaimable) reclaim_n++;
      end
    end
    fail_count     <= mismatches;
    pending        <= expected_results.size();
    results_seen   <= checked;
    freed_seen     <= freed_n;
    saturated_seen <= saturated_n;
    reclaim_seen   <= reclaim_n;
  end

endmodule

// ===== dv/tb_dedup_block_refcount_table_unit.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_dedup_block_refcount_table_unit
// Drives request transactions into the refcount table with random gaps and
// result stalls; a checker beside the block predicts and compares results.
// ---------------------------------------------------------------------------
module tb_dedup_block_refcount_table_unit;
  import drct_pkg::*;

  // Stimulus sizing
  localparam int RANDOM_ITEMS   = 1800;
  localparam int HOT_N          = 8;      // small working set so counts interact
  localparam int PRESSURE_AT    = 950;    // item index where the long hold-off starts
  localparam int HOLD_CYCLES    = 300;    // receiver hold-off length
  localparam int TAIL_CYCLES    = 20;     // drain after the last expected result
  // Longest quiet stretch: the clearing pass over the table, or the receiver hold-off,
  // plus the longest gap/stall; taken several times over.
  localparam int WATCHDOG_LIMIT = 5000;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [TYPE_W-1:0] in_req_type;
  logic [ID_W-1:0]   in_block_id;
  logic [VAL_W-1:0]  in_load_value;
  logic [VAL_W-1:0]  in_file_refs;
  logic              out_valid;
  logic              out_stall;
  logic [VAL_W-1:0]  out_ref_count;
  logic              out_became_free;
  logic              out_still_shared;
  logic              out_present;
  logic              out_reclaimable;
  logic              out_range_error;
  logic [TOT_W-1:0]  out_freed_total;
  logic [TOT_W-1:0]  out_shared_total;

  int fail_count;
  int pending;
  int results_seen;
  int freed_seen;
  int saturated_seen;
  int reclaim_seen;

  // Sender / receiver coordination
  logic            burst_mode = 1'b0;  // sender offers back to back
  logic            hold_req   = 1'b0;  // sender asks for the long hold-off
  logic            holding    = 1'b0;  // receiver is in the hold-off
  int              sent_count = 0;
  int              idle_cycles = 0;
  logic [ID_W-1:0] hot_ids [HOT_N];

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  dedup_block_refcount_table_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_req_type      (in_req_type),
    .in_block_id      (in_block_id),
    .in_load_value    (in_load_value),
    .in_file_refs     (in_file_refs),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_ref_count    (out_ref_count),
    .out_became_free  (out_became_free),
    .out_still_shared (out_still_shared),
    .out_present      (out_present),
    .out_reclaimable  (out_reclaimable),
    .out_range_error  (out_range_error),
    .out_freed_total  (out_freed_total),
    .out_shared_total (out_shared_total)
  );

  refcount_table_checker refcount_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_req_type      (in_req_type),
    .in_block_id      (in_block_id),
    .in_load_value    (in_load_value),
    .in_file_refs     (in_file_refs),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_ref_count    (out_ref_count),
    .out_became_free  (out_became_free),
    .out_still_shared (out_still_shared),
    .out_present      (out_present),
    .out_reclaimable  (out_reclaimable),
    .out_range_error  (out_range_error),
    .out_freed_total  (out_freed_total),
    .out_shared_total (out_shared_total),
    .fail_count       (fail_count),
    .pending          (pending),
    .results_seen     (results_seen),
    .freed_seen       (freed_seen),
    .saturated_seen   (saturated_seen),
    .reclaim_seen     (reclaim_seen)
  );

  // Gap length before the next transaction: mostly none or short, a few long.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  // Offers one request transaction and returns at the edge where it is taken.
  // Valid stays high across back-to-back transactions; it only drops for a gap.
  task automatic send_request(input op_t op, input logic [ID_W-1:0] id,
                              input logic [VAL_W-1:0] load_v,
                              input logic [VAL_W-1:0] file_v);
    int gap;
    gap = burst_mode ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_req_type   <= op;
    in_block_id   <= id;
    in_load_value <= load_v;
    in_file_refs  <= file_v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_count++;
  endtask

  // Random request: mostly aimed at the hot set with small counts so that
  // releases hit zero and free blocks, some near-max loads so adds saturate,
  // and full-width values so every bit toggles.
  task automatic send_random_item();
    op_t             op;
    logic [ID_W-1:0] id;
    logic [VAL_W-1:0] load_v;
    logic [VAL_W-1:0] file_v;
    int              roll;
    roll = $urandom_range(0, 99);
    if (roll < 15)      op = OP_LOAD;
    else if (roll < 50) op = OP_RELEASE;
    else if (roll < 80) op = OP_ADD;
    else                op = OP_QUERY;
    if ($urandom_range(0, 9) < 7) id = hot_ids[$urandom_range(0, HOT_N - 1)];
    else                          id = ID_W'($urandom);
    roll = $urandom_range(0, 9);
    if (roll < 5)      load_v = VAL_W'($urandom_range(0, 4));
    else if (roll < 7) load_v = VAL_W'(CNT_MAX - $urandom_range(0, 2));
    else               load_v = VAL_W'($urandom);
    roll = $urandom_range(0, 9);
    if (roll < 6)      file_v = VAL_W'($urandom_range(0, 4));
    else if (roll < 7) file_v = VAL_W'(CNT_MAX - $urandom_range(0, 2));
    else               file_v = VAL_W'($urandom);
    send_request(op, id, load_v, file_v);
  endtask

  // ---------------------------------------------------------------------------
  // Request side: reset, directed cases, random traffic, drain and verdict.
  // ---------------------------------------------------------------------------
  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_req_type   = OP_LOAD;
    in_block_id   = '0;
    in_load_value = '0;
    in_file_refs  = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: table is clear after reset
    send_request(OP_QUERY,   ID_W'(0),    VAL_W'(0),      VAL_W'(0));      // empty, matches 0
    send_request(OP_RELEASE, ID_W'(0),    VAL_W'(0),      VAL_W'(0));      // release at zero
    send_request(OP_ADD,     ID_W'(0),    VAL_W'(0),      VAL_W'(0));
    send_request(OP_RELEASE, ID_W'(0),    VAL_W'(0),      VAL_W'(0));      // back to free
    // top block at the maximum count: add saturates
    send_request(OP_LOAD,    ID_W'(1023), VAL_W'(CNT_MAX), VAL_W'(0));
    send_request(OP_ADD,     ID_W'(1023), VAL_W'(0),      VAL_W'(0));
    send_request(OP_QUERY,   ID_W'(1023), VAL_W'(0),      VAL_W'(CNT_MAX));
    send_request(OP_RELEASE, ID_W'(1023), VAL_W'(0),      VAL_W'(0));      // still shared
    send_request(OP_QUERY,   ID_W'(1023), VAL_W'(0),      VAL_W'(CNT_MAX));
    // single reference: release frees, second release saturates
    send_request(OP_LOAD,    ID_W'(5),    VAL_W'(1),      VAL_W'(0));
    send_request(OP_RELEASE, ID_W'(5),    VAL_W'(0),      VAL_W'(0));
    send_request(OP_RELEASE, ID_W'(5),    VAL_W'(0),      VAL_W'(0));
    send_request(OP_ADD,     ID_W'(5),    VAL_W'(0),      VAL_W'(0));
    send_request(OP_ADD,     ID_W'(5),    VAL_W'(0),      VAL_W'(0));
    send_request(OP_QUERY,   ID_W'(5),    VAL_W'(0),      VAL_W'(2));      // reclaimable
    send_request(OP_QUERY,   ID_W'(5),    VAL_W'(0),      VAL_W'(3));      // not reclaimable
    // alternating bit patterns on id, load value and file refs
    send_request(OP_LOAD,    ID_W'(10'h2AA), VAL_W'(16'hAAAA), VAL_W'(16'h5555));
    send_request(OP_LOAD,    ID_W'(10'h155), VAL_W'(16'h5555), VAL_W'(16'hAAAA));
    send_request(OP_QUERY,   ID_W'(10'h2AA), VAL_W'(16'h5555), VAL_W'(16'hAAAA));
    send_request(OP_QUERY,   ID_W'(10'h155), VAL_W'(16'hAAAA), VAL_W'(16'h5555));
    send_request(OP_LOAD,    ID_W'(10'h155), VAL_W'(0),      VAL_W'(CNT_MAX));
    send_request(OP_QUERY,   ID_W'(10'h155), VAL_W'(CNT_MAX), VAL_W'(0));

    // Random traffic
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 128 == 0) begin
        for (int h = 0; h < HOT_N; h++) hot_ids[h] = ID_W'($urandom);
        // keep the edge blocks in play now and then
        if ($urandom_range(0, 1)) hot_ids[0] = '0;
        else                      hot_ids[0] = '1;
      end
      // every 100 transactions: a third of the chunks are sent back to back
      if (n % 100 == 0) burst_mode = ($urandom_range(0, 2) == 0);
      if (n == PRESSURE_AT) begin
        // drop valid, ask the receiver to hold off, then push back to back
        // so the queue and output register fill and in_stall rises
        in_valid <= 1'b0;
        hold_req = 1'b1;
        while (!holding) @(posedge clk);
        burst_mode = 1'b1;
      end
      send_random_item();
    end
    in_valid <= 1'b0;

    // Drain: first let the pending count take in the last transaction,
    // then wait for every expected result back and a few more cycles for strays
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Run summary: %0d requests sent, %0d results compared field by field.",
             sent_count, results_seen);
    $display("Outcomes seen: %0d blocks freed, %0d saturated requests, %0d reclaimable queries.",
             freed_seen, saturated_seen, reclaim_seen);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Result side: alternating stall runs and free runs, mostly short, some long,
  // plus the one long hold-off that the request side asks for.
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int run;
    int k;
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_req) begin
        hold_req  = 1'b0;
        holding   = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        holding   = 1'b0;
      end else begin
        run = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
        out_stall <= 1'b1;
        repeat (run) @(posedge clk);
      end
      // free run; long ones give stretches with no stalling at all
      run = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 200) : $urandom_range(1, 6);
      out_stall <= 1'b0;
      k = 0;
      do begin
        @(posedge clk);
        k++;
      end while (k < run && !hold_req);
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: cycles in which neither channel moves a transaction.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired, no transaction for %0d cycles, %0d results pending",
                 $time, idle_cycles, pending);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

endmodule
